// ----- rtl/ssbs_pkg.sv -----
// shared types and constants of the stereo block sad scorer
`timescale 1ns / 1ps
package ssbs_pkg;

  // field widths
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 16;
  localparam int TOT_W   = SUM_W + 1;
  localparam int SCORE_W = 25;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W   = $clog2(SCORE_W);

  // score scaling and divide-by-ten reciprocal (exact for totals below 2**18)
  localparam logic [8:0]  SCORE_SCALE  = 9'd333;
  localparam int          RECIP_W      = 16;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 16'd52429;
  localparam int          DIV10_SHIFT  = 19;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAD_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIMIT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_THRESHOLD = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] SAD_THRESHOLD_RST     = 16'd90;
  localparam logic [CFG_W-1:0] EDGE_LIMIT_RST        = 16'd0;
  localparam logic [CFG_W-1:0] TEXTURE_THRESHOLD_RST = 16'd200;

  typedef struct packed {
    logic [PIX_W-1:0] left_pixel;
    logic [PIX_W-1:0] right_pixel;
    logic [PIX_W-1:0] left_edge;
    logic [PIX_W-1:0] right_edge;
    logic             pixel_used;
    logic             block_last;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               hit;
    logic               low_texture;
    logic [SUM_W-1:0]   raw_sad;
    logic [SUM_W-1:0]   left_texture;
    logic [SUM_W-1:0]   right_texture;
  } out_item_t;

  // sums of one finished block
  typedef struct packed {
    logic [SUM_W-1:0] sad;
    logic [SUM_W-1:0] left;
    logic [SUM_W-1:0] right;
  } blk_sums_t;

  typedef struct packed {
    logic [CFG_W-1:0] sad_threshold;
    logic [CFG_W-1:0] edge_limit;
    logic [CFG_W-1:0] texture_threshold;
  } cfg_regs_t;

endpackage

// ----- rtl/ssbs_front.sv -----
// pixel accumulator: sums absolute differences and edge values per block
`timescale 1ns / 1ps
module ssbs_front
  import ssbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      blk_push,
  output blk_sums_t blk_sums
);

  logic [SUM_W-1:0] sad_r, sad_nxt;
  logic [SUM_W-1:0] left_r, left_nxt;
  logic [SUM_W-1:0] right_r, right_nxt;
  logic [PIX_W-1:0] abs_diff;
  logic [SUM_W:0]   sad_add, left_add, right_add;

  // absolute pixel difference
  always_comb begin
    if (in_item.left_pixel > in_item.right_pixel) begin
      abs_diff = in_item.left_pixel - in_item.right_pixel;
    end else begin
      abs_diff = in_item.right_pixel - in_item.left_pixel;
    end
  end

  // saturating sums including this pixel
  always_comb begin
    sad_add   = {1'b0, sad_r} + (SUM_W+1)'(abs_diff);
    left_add  = {1'b0, left_r} + (SUM_W+1)'(in_item.left_edge);
    right_add = {1'b0, right_r} + (SUM_W+1)'(in_item.right_edge);
    blk_sums.sad   = sad_r;
    blk_sums.left  = left_r;
    blk_sums.right = right_r;
    if (in_item.pixel_used) begin
      blk_sums.sad   = sad_add[SUM_W] ? '1 : sad_add[SUM_W-1:0];
      blk_sums.left  = left_add[SUM_W] ? '1 : left_add[SUM_W-1:0];
      blk_sums.right = right_add[SUM_W] ? '1 : right_add[SUM_W-1:0];
    end
  end

  // hand the block on at its last pixel and restart the sums
  always_comb begin
    blk_push  = in_valid && in_item.block_last;
    sad_nxt   = sad_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (in_valid) begin
      if (in_item.block_last) begin
        sad_nxt   = '0;
        left_nxt  = '0;
        right_nxt = '0;
      end else begin
        sad_nxt   = blk_sums.sad;
        left_nxt  = blk_sums.left;
        right_nxt = blk_sums.right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sad_r   <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      sad_r   <= sad_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

// ----- rtl/ssbs_queue.sv -----
// short queue of finished block sums between accumulator and scorer
`timescale 1ns / 1ps
module ssbs_queue
  import ssbs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  blk_sums_t wr_data,
  input  logic      pop,
  output blk_sums_t rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blk_sums_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/ssbs_back.sv -----
// block scorer: texture checks, bit-serial division and result register
`timescale 1ns / 1ps
module ssbs_back
  import ssbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      blk_avail,
  input  blk_sums_t blk_sums,
  output logic      blk_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  blk_sums_t          sums_r;
  logic               low_r;
  logic [TOT_W-1:0]   divisor_r;
  logic [TOT_W-1:0]   rem_r, rem_nxt;
  logic [SCORE_W-1:0] quo_r, quo_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;

  logic [TOT_W-1:0]         total;
  logic                     tex_low, low;
  logic [TOT_W+RECIP_W-1:0] recip_prod;
  logic [TOT_W-1:0]         divisor;
  logic [SCORE_W-1:0]       scaled_sad;
  logic [TOT_W:0]           trial;
  logic                     fits;
  logic                     out_load;
  out_item_t                result;

  // edge total, texture checks and scaled dividend
  always_comb begin
    total      = {1'b0, sums_r.left} + {1'b0, sums_r.right};
    tex_low    = (sums_r.left < cfg.texture_threshold) ||
                 (sums_r.right < cfg.texture_threshold);
    low        = (sums_r.left < cfg.edge_limit) || (sums_r.right < cfg.edge_limit);
    recip_prod = (TOT_W+RECIP_W)'(total) * (TOT_W+RECIP_W)'(DIV10_RECIP);
    divisor    = tex_low ? TOT_W'(recip_prod[TOT_W+RECIP_W-1:DIV10_SHIFT]) : total;
    scaled_sad = SCORE_W'(sums_r.sad) * SCORE_W'(SCORE_SCALE);
  end

  // one restoring division step
  always_comb begin
    trial   = {rem_r, quo_r[SCORE_W-1]};
    fits    = (trial >= {1'b0, divisor_r});
    rem_nxt = fits ? TOT_W'(trial - {1'b0, divisor_r}) : trial[TOT_W-1:0];
    quo_nxt = {quo_r[SCORE_W-2:0], fits};
  end

  // final result fields
  always_comb begin
    result.low_texture   = low_r;
    result.raw_sad       = sums_r.sad;
    result.left_texture  = sums_r.left;
    result.right_texture = sums_r.right;
    if (low_r) begin
      result.score = '0;
      result.hit   = 1'b0;
    end else if (divisor_r == '0) begin
      result.score = '1;
      result.hit   = 1'b0;
    end else begin
      result.score = quo_r;
      result.hit   = (quo_r < SCORE_W'(cfg.sad_threshold));
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    blk_pop       = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      ST_IDLE: begin
        if (blk_avail) begin
          blk_pop   = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_nxt   = CNT_W'(SCORE_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (blk_pop) begin
      sums_r <= blk_sums;
    end
    if (state_r == ST_PREP) begin
      low_r     <= low;
      divisor_r <= divisor;
      rem_r     <= '0;
      quo_r     <= scaled_sad;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (out_load) begin
      out_item_r <= result;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/stereo_block_sad_scorer.sv -----
// top level of the stereo block sad scorer
//
//   channel  ports                                   transfer when
//   in       in_push, in_full, in_data               in_push && !in_full
//   out      out_empty, out_pop, out_data            out_pop && !out_empty
//   cfg      cfg_we, cfg_index, cfg_wdata            cfg_we (index 3 ignored)
//
// pixels are taken one per cycle while in_full is low; a block's last pixel
// passes its sums to a queue of QUEUE_DEPTH entries. the scorer takes one
// block at a time (load, prepare, 25 divider steps, write-back) and pops the
// next only after write-back. in_full rises while the queue is full; a held
// result (out_pop low) stalls the scorer at write-back only. reset is
// synchronous and clears sums, queue, sequencer and configuration.
`timescale 1ns / 1ps
module stereo_block_sad_scorer
  import ssbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic      in_accept;
  logic      blk_push, blk_pop, q_full, q_empty;
  blk_sums_t front_sums, q_sums;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAD_THRESHOLD:     cfg_nxt.sad_threshold     = cfg_wdata;
        CFG_EDGE_LIMIT:        cfg_nxt.edge_limit        = cfg_wdata;
        CFG_TEXTURE_THRESHOLD: cfg_nxt.texture_threshold = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sad_threshold     <= SAD_THRESHOLD_RST;
      cfg_r.edge_limit        <= EDGE_LIMIT_RST;
      cfg_r.texture_threshold <= TEXTURE_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accumulator
  ssbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .in_item  (in_data),
    .blk_push (blk_push),
    .blk_sums (front_sums)
  );

  // block queue
  ssbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (blk_push),
    .wr_data (front_sums),
    .pop     (blk_pop),
    .rd_data (q_sums),
    .full    (q_full),
    .empty   (q_empty)
  );

  // scorer
  ssbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .blk_avail (!q_empty),
    .blk_sums  (q_sums),
    .blk_pop   (blk_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_data)
  );

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the stereo block sad scorer: pixel stream in, block scores out
`timescale 1ns / 1ps
module tb_top;
  import ssbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int PHASES        = 8;
  localparam int PHASE_PIXELS  = 145;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 60;
  localparam int TEXTURE_DIV   = 10;
  localparam int SHOW_LIMIT    = 10;

  typedef enum int {
    STYLE_RANDOM, STYLE_MATCHED, STYLE_FLAT, STYLE_BLANK, STYLE_BRIGHT
  } pixel_style_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_item_t             in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // pending pixels, expected block scores and the bench's copy of the registers
  in_item_t    pixel_q[$];
  out_item_t   block_score_q[$];
  cfg_regs_t   thresholds = '{SAD_THRESHOLD_RST, EDGE_LIMIT_RST, TEXTURE_THRESHOLD_RST};
  blk_sums_t   running    = '0;
  int unsigned queued_pixels = 0;
  int unsigned taken_pixels  = 0;
  int unsigned bad_results   = 0;
  int unsigned feed_wait     = 0;
  int unsigned drain_wait    = 0;
  bit          feed_calm     = 1'b0;
  bit          drain_calm    = 1'b0;
  bit          push_next;
  bit          pop_next;

  stereo_block_sad_scorer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // sums stick at all ones
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, int unsigned v);
    int unsigned s;
    s = acc + v;
    return (s > 32'hFFFF) ? '1 : s[SUM_W-1:0];
  endfunction

  // accumulate one pixel pair; on the block's last pixel queue the expected score
  function automatic void score_pixel(in_item_t px);
    int unsigned diff;
    int unsigned total;
    int unsigned quot;
    out_item_t   want;
    if (px.pixel_used) begin
      diff = (px.left_pixel > px.right_pixel) ? px.left_pixel - px.right_pixel
                                              : px.right_pixel - px.left_pixel;
      running.sad   = sat_add(running.sad, diff);
      running.left  = sat_add(running.left, px.left_edge);
      running.right = sat_add(running.right, px.right_edge);
    end
    if (!px.block_last) return;
    total = running.left + running.right;
    if (running.left < thresholds.texture_threshold ||
        running.right < thresholds.texture_threshold)
      total = total / TEXTURE_DIV;
    want = '0;
    want.low_texture = (running.left < thresholds.edge_limit) ||
                       (running.right < thresholds.edge_limit);
    if (want.low_texture) begin
      want.score = '0;
      want.hit   = 1'b0;
    end else if (total == 0) begin
      want.score = '1;
      want.hit   = 1'b0;
    end else begin
      quot       = (SCORE_SCALE * running.sad) / total;
      want.score = quot[SCORE_W-1:0];
      want.hit   = quot < thresholds.sad_threshold;
    end
    want.raw_sad       = running.sad;
    want.left_texture  = running.left;
    want.right_texture = running.right;
    block_score_q.insert(block_score_q.size(), want);
    running = '0;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("score %0d hit %0d low %0d sad %0d left %0d right %0d",
                     r.score, r.hit, r.low_texture, r.raw_sad, r.left_texture,
                     r.right_texture);
  endfunction

  // compare a popped result with the oldest expected score
  function automatic void check_block(out_item_t got);
    out_item_t want;
    if (block_score_q.size() == 0) begin
      bad_results++;
      if (bad_results <= SHOW_LIMIT) $display("unexpected result: %s", show(got));
      return;
    end
    want = block_score_q.pop_front();
    if (got.score !== want.score || got.hit !== want.hit ||
        got.low_texture !== want.low_texture || got.raw_sad !== want.raw_sad ||
        got.left_texture !== want.left_texture || got.right_texture !== want.right_texture)
    begin
      bad_results++;
      if (bad_results <= SHOW_LIMIT)
        $display("mismatch: expected %s, got %s", show(want), show(got));
    end
  endfunction

  // input driver: one pixel per transfer, random gaps with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push   <= 1'b0;
      feed_wait = 0;
    end else begin
      push_next = in_push;
      if (in_push && !in_full) begin
        score_pixel(in_data);
        taken_pixels++;
        if ($urandom_range(0, 79) == 0) feed_calm = ~feed_calm;
        feed_wait = feed_calm ? 0 : $urandom_range(0, 7);
        push_next = 1'b0;
      end
      if (!push_next) begin
        if (feed_wait > 0) begin
          feed_wait--;
        end else if (pixel_q.size() > 0) begin
          in_data   <= pixel_q.pop_front();
          push_next = 1'b1;
        end
      end
      in_push <= push_next;
    end
  end

  // result monitor: pop with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop    <= 1'b0;
      drain_wait = 0;
    end else begin
      pop_next = out_pop;
      if (out_pop && !out_empty) begin
        check_block(out_data);
        if ($urandom_range(0, 39) == 0) drain_calm = ~drain_calm;
        drain_wait = drain_calm ? 0 : $urandom_range(0, 7);
        pop_next = 1'b0;
      end
      if (!pop_next) begin
        if (drain_wait > 0) drain_wait--;
        else pop_next = 1'b1;
      end
      out_pop <= pop_next;
    end
  end

  // register write, mirrored into the bench copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SAD_THRESHOLD:     thresholds.sad_threshold     = val;
      CFG_EDGE_LIMIT:        thresholds.edge_limit        = val;
      CFG_TEXTURE_THRESHOLD: thresholds.texture_threshold = val;
      default: ;
    endcase
  endtask

  // wait until every pixel is taken and every score is back, then let the scorer go quiet
  task automatic settle();
    while (taken_pixels != queued_pixels || block_score_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixel(input int lp, input int rp, input int le, input int re,
                             input bit used, input bit last);
    in_item_t px;
    px.left_pixel  = lp[PIX_W-1:0];
    px.right_pixel = rp[PIX_W-1:0];
    px.left_edge   = le[PIX_W-1:0];
    px.right_edge  = re[PIX_W-1:0];
    px.pixel_used  = used;
    px.block_last  = last;
    pixel_q.insert(pixel_q.size(), px);
    queued_pixels++;
  endtask

  // one block of len pixels in the given style, a share of them marked unused
  task automatic queue_block(input pixel_style_t style, input int len, input int unused_pct);
    int lp, rp, le, re;
    for (int i = 0; i < len; i++) begin
      lp = $urandom_range(0, 255);
      rp = $urandom_range(0, 255);
      le = $urandom_range(0, 255);
      re = $urandom_range(0, 255);
      case (style)
        STYLE_MATCHED: begin
          rp = lp + $urandom_range(0, 6) - 3;
          if (rp < 0) rp = 0;
          if (rp > 255) rp = 255;
        end
        STYLE_FLAT: begin
          le = $urandom_range(0, 15);
          re = $urandom_range(0, 15);
        end
        STYLE_BLANK: begin
          le = 0;
          re = 0;
        end
        STYLE_BRIGHT: begin
          lp = 255;
          rp = 0;
          le = 255;
          re = 255;
        end
        default: ;
      endcase
      queue_pixel(lp, rp, le, re, $urandom_range(0, 99) >= unused_pct, i == len - 1);
    end
  endtask

  // stimulus and end of run
  initial begin
    pixel_style_t style;
    int           len;
    int           filled;
    int           pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed blocks at reset settings
    queue_pixel(255, 0, 255, 255, 1, 1);        // extremes, one-pixel block
    queue_pixel(0, 255, 0, 0, 1, 1);            // no texture at all: zero divisor
    queue_pixel(17, 99, 3, 4, 0, 1);            // empty block
    queue_pixel(10, 20, 100, 150, 1, 0);        // unused last pixel after three used
    queue_pixel(90, 30, 120, 110, 1, 0);
    queue_pixel(5, 250, 130, 140, 1, 0);
    queue_pixel(255, 0, 255, 255, 0, 1);
    for (int i = 0; i < 5; i++) queue_pixel(128, 128, 200, 220, 1, i == 4);  // perfect match
    for (int i = 0; i < 4; i++) queue_pixel(50, 40, 10, 12, 1, i == 3);      // thin texture
    queue_pixel(0, 0, 0, 0, 1, 0);
    queue_pixel(0, 0, 0, 0, 1, 1);
    queue_pixel(200, 0, 5, 6, 1, 1);            // total shrinks to one after the divide

    // random phases, each under its own register settings
    for (int p = 1; p <= PHASES; p++) begin
      settle();
      case (p)
        1: begin
          write_reg(CFG_SAD_THRESHOLD, 16'hFFFF);
          write_reg(CFG_EDGE_LIMIT, 16'hFFFF);
          write_reg(CFG_TEXTURE_THRESHOLD, 16'h0000);
          write_reg(CFG_SPARE, CFG_W'($urandom));
        end
        2: begin
          write_reg(CFG_SAD_THRESHOLD, 16'h0000);
          write_reg(CFG_EDGE_LIMIT, 16'h0000);
          write_reg(CFG_TEXTURE_THRESHOLD, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_SAD_THRESHOLD, SAD_THRESHOLD_RST);
          write_reg(CFG_EDGE_LIMIT, EDGE_LIMIT_RST);
          write_reg(CFG_TEXTURE_THRESHOLD, TEXTURE_THRESHOLD_RST);
        end
        default: begin
          write_reg(CFG_SAD_THRESHOLD, CFG_W'($urandom_range(0, 400)));
          write_reg(CFG_EDGE_LIMIT, (p == 6) ? CFG_W'($urandom_range(0, 65535))
                                             : CFG_W'($urandom_range(0, 4000)));
          write_reg(CFG_TEXTURE_THRESHOLD, CFG_W'($urandom_range(0, 4000)));
          if (p % 2 == 0) write_reg(CFG_SPARE, CFG_W'($urandom));
        end
      endcase

      // overlong block drives every sum into saturation
      if (p == 1 || p == 5) queue_block(STYLE_BRIGHT, 270, 0);

      filled = 0;
      while (filled < PHASE_PIXELS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      style = STYLE_RANDOM;
        else if (pick < 65) style = STYLE_MATCHED;
        else if (pick < 85) style = STYLE_FLAT;
        else if (pick < 92) style = STYLE_BLANK;
        else                style = STYLE_BRIGHT;
        len = ($urandom_range(0, 99) < 70) ? 25 : $urandom_range(1, 40);
        queue_block(style, len, ($urandom_range(0, 99) < 4) ? 100 : 10);
        filled += len;
      end
    end

    // drain and report
    while (taken_pixels != queued_pixels || block_score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && block_score_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ssbs_pkg.sv
rtl/ssbs_front.sv
rtl/ssbs_queue.sv
rtl/ssbs_back.sv
rtl/stereo_block_sad_scorer.sv
bench/tb_top.sv
